// File: src/vrbs_pkg.sv
package vrbs_pkg;

	localparam int VIP_SLOTS    = 16;
	localparam int MAX_BACKENDS = 64;
	localparam int QUEUE_DEPTH  = 2;
	localparam int BACKEND_DEPTH = VIP_SLOTS * MAX_BACKENDS;

	localparam int SLOT_W  = (VIP_SLOTS > 1) ? $clog2(VIP_SLOTS) : 1;
	localparam int ADDR_W  = (BACKEND_DEPTH > 1) ? $clog2(BACKEND_DEPTH) : 1;
	localparam int CNT_W   = 7;
	localparam int PROD_W  = 32 + CNT_W;
	localparam int QPTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

	localparam logic [1:0] CMD_CONNECT = 2'd0;
	localparam logic [1:0] CMD_SLOT    = 2'd1;
	localparam logic [1:0] CMD_BACKEND = 2'd2;

	localparam logic [15:0] FAMILY_IPV4 = 16'd2;

	localparam logic [1:0] OP_ECHO  = 2'd0;
	localparam logic [1:0] OP_DROP  = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;
	localparam logic [1:0] OP_WRITE = 2'd3;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [15:0] addr_family;
		logic [31:0] virtual_ip;
		logic [15:0] orig_port;
		logic [31:0] random_word;
		logic [3:0]  slot_sel;
		logic        slot_enable;
		logic [6:0]  slot_count;
		logic [5:0]  backend_pos;
		logic [31:0] backend_addr;
		logic [15:0] backend_port_in;
	} item_t;

	typedef struct packed {
		logic [1:0]        op;
		logic [ADDR_W-1:0] addr;
		logic [31:0]       echo_ip;
		logic [15:0]       echo_port;
		logic [31:0]       wr_ip;
		logic [15:0]       wr_port;
	} op_entry_t;

	typedef struct packed {
		logic        verdict;
		logic        rewritten;
		logic [31:0] dest_ip;
		logic [15:0] dest_port;
	} result_t;

endpackage

// File: src/vrbs_front.sv
module vrbs_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  vrbs_pkg::item_t      in_item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output vrbs_pkg::op_entry_t  out_entry
);

	function automatic logic [vrbs_pkg::ADDR_W-1:0] bk_addr(
		input logic [vrbs_pkg::SLOT_W-1:0] slot,
		input logic [vrbs_pkg::ADDR_W-1:0] idx
	);
		bk_addr = vrbs_pkg::ADDR_W'(slot) * vrbs_pkg::ADDR_W'(vrbs_pkg::MAX_BACKENDS) + idx;
	endfunction

	logic [31:0]                 slot_key_q   [vrbs_pkg::VIP_SLOTS];
	logic [vrbs_pkg::VIP_SLOTS-1:0] slot_valid_q;
	logic [vrbs_pkg::CNT_W-1:0]  slot_count_q [vrbs_pkg::VIP_SLOTS];

	logic                        valid_s1;
	vrbs_pkg::item_t             item_s1;
	logic                        adv_s1;

	logic                        hit_c;
	logic [vrbs_pkg::SLOT_W-1:0] hit_slot_c;
	logic [vrbs_pkg::CNT_W-1:0]  hit_count_c;
	logic [vrbs_pkg::CNT_W-1:0]  clamp_c;
	logic [1:0]                  op_c;
	logic                        sel_ok_c;
	logic                        pos_ok_c;
	logic [vrbs_pkg::SLOT_W-1:0] sel_slot_c;

	logic                        valid_s2;
	logic [1:0]                  op_s2;
	logic [vrbs_pkg::ADDR_W-1:0] addr_s2;
	logic [vrbs_pkg::SLOT_W-1:0] slot_s2;
	logic [vrbs_pkg::CNT_W-1:0]  n_s2;
	logic [31:0]                 rnd_s2;
	logic [31:0]                 vip_s2;
	logic [15:0]                 port_s2;
	logic [31:0]                 baddr_s2;
	logic [15:0]                 bport_s2;
	logic [vrbs_pkg::PROD_W-1:0] prod_c;
	logic [vrbs_pkg::ADDR_W-1:0] rd_addr_c;

	assign adv_s1   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv_s1;

	assign sel_ok_c   = 32'(item_s1.slot_sel) < vrbs_pkg::VIP_SLOTS;
	assign pos_ok_c   = 32'(item_s1.backend_pos) < vrbs_pkg::MAX_BACKENDS;
	assign sel_slot_c = vrbs_pkg::SLOT_W'(item_s1.slot_sel);

	always_comb begin
		hit_c      = 1'b0;
		hit_slot_c = '0;
		for (int i = vrbs_pkg::VIP_SLOTS - 1; i >= 0; i--) begin
			if (slot_valid_q[i] && slot_key_q[i] == item_s1.virtual_ip) begin
				hit_c      = 1'b1;
				hit_slot_c = vrbs_pkg::SLOT_W'(i);
			end
		end
		hit_count_c = slot_count_q[hit_slot_c];
		if (32'(hit_count_c) > vrbs_pkg::MAX_BACKENDS) begin
			clamp_c = vrbs_pkg::CNT_W'(vrbs_pkg::MAX_BACKENDS);
		end else begin
			clamp_c = hit_count_c;
		end
	end

	always_comb begin
		priority if (item_s1.cmd == vrbs_pkg::CMD_SLOT) begin
			op_c = vrbs_pkg::OP_ECHO;
		end else if (item_s1.cmd == vrbs_pkg::CMD_BACKEND) begin
			op_c = (sel_ok_c && pos_ok_c) ? vrbs_pkg::OP_WRITE : vrbs_pkg::OP_ECHO;
		end else if (item_s1.cmd == vrbs_pkg::CMD_CONNECT &&
			     item_s1.addr_family == vrbs_pkg::FAMILY_IPV4 && hit_c) begin
			op_c = (hit_count_c == '0) ? vrbs_pkg::OP_DROP : vrbs_pkg::OP_READ;
		end else begin
			op_c = vrbs_pkg::OP_ECHO;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (!valid_s2 || out_ready) begin
				valid_s2 <= adv_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
		if (adv_s1) begin
			op_s2    <= op_c;
			addr_s2  <= bk_addr(sel_slot_c, vrbs_pkg::ADDR_W'(item_s1.backend_pos));
			slot_s2  <= hit_slot_c;
			n_s2     <= clamp_c;
			rnd_s2   <= item_s1.random_word;
			vip_s2   <= item_s1.virtual_ip;
			port_s2  <= item_s1.orig_port;
			baddr_s2 <= item_s1.backend_addr;
			bport_s2 <= item_s1.backend_port_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
			for (int i = 0; i < vrbs_pkg::VIP_SLOTS; i++) begin
				slot_count_q[i] <= '0;
			end
		end else if (adv_s1 && item_s1.cmd == vrbs_pkg::CMD_SLOT && sel_ok_c) begin
			slot_valid_q[sel_slot_c] <= item_s1.slot_enable;
			slot_count_q[sel_slot_c] <= item_s1.slot_count;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && item_s1.cmd == vrbs_pkg::CMD_SLOT && sel_ok_c) begin
			slot_key_q[sel_slot_c] <= item_s1.virtual_ip;
		end
	end

	assign prod_c    = vrbs_pkg::PROD_W'(rnd_s2) * vrbs_pkg::PROD_W'(n_s2);
	assign rd_addr_c = bk_addr(slot_s2, vrbs_pkg::ADDR_W'(prod_c[vrbs_pkg::PROD_W-1:32]));

	assign out_valid           = valid_s2;
	assign out_entry.op        = op_s2;
	assign out_entry.addr      = (op_s2 == vrbs_pkg::OP_READ) ? rd_addr_c : addr_s2;
	assign out_entry.echo_ip   = vip_s2;
	assign out_entry.echo_port = port_s2;
	assign out_entry.wr_ip     = baddr_s2;
	assign out_entry.wr_port   = bport_s2;

endmodule

// File: src/vrbs_queue.sv
module vrbs_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push_valid,
	output logic                 push_ready,
	input  vrbs_pkg::op_entry_t  push_entry,
	output logic                 pop_valid,
	input  logic                 pop_ready,
	output vrbs_pkg::op_entry_t  pop_entry
);

	vrbs_pkg::op_entry_t         entries_q [vrbs_pkg::QUEUE_DEPTH];
	logic [vrbs_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [vrbs_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [vrbs_pkg::QCNT_W-1:0] count_q;
	logic                        do_push;
	logic                        do_pop;

	assign push_ready = 32'(count_q) < vrbs_pkg::QUEUE_DEPTH;
	assign pop_valid  = count_q != '0;
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_entry  = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				if (32'(wr_ptr_q) == vrbs_pkg::QUEUE_DEPTH - 1) begin
					wr_ptr_q <= '0;
				end else begin
					wr_ptr_q <= wr_ptr_q + 1'b1;
				end
			end
			if (do_pop) begin
				if (32'(rd_ptr_q) == vrbs_pkg::QUEUE_DEPTH - 1) begin
					rd_ptr_q <= '0;
				end else begin
					rd_ptr_q <= rd_ptr_q + 1'b1;
				end
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

// File: src/vrbs_back.sv
module vrbs_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  vrbs_pkg::op_entry_t  in_entry,
	output logic                 out_valid,
	input  logic                 out_ready,
	output vrbs_pkg::result_t    out_result
);

	logic [31:0]       ip_mem   [vrbs_pkg::BACKEND_DEPTH];
	logic [15:0]       port_mem [vrbs_pkg::BACKEND_DEPTH];
	logic [31:0]       rd_ip_q;
	logic [15:0]       rd_port_q;

	logic              valid_b1;
	logic [1:0]        op_b1;
	logic [31:0]       echo_ip_b1;
	logic [15:0]       echo_port_b1;
	logic              adv_b1;
	logic              pop;

	logic              out_valid_q;
	vrbs_pkg::result_t result_q;

	assign adv_b1   = valid_b1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_b1 || adv_b1;
	assign pop      = in_valid && in_ready;

	always_ff @(posedge clk) begin
		if (pop && in_entry.op == vrbs_pkg::OP_WRITE) begin
			ip_mem[in_entry.addr]   <= in_entry.wr_ip;
			port_mem[in_entry.addr] <= in_entry.wr_port;
		end
		if (pop && in_entry.op == vrbs_pkg::OP_READ) begin
			rd_ip_q   <= ip_mem[in_entry.addr];
			rd_port_q <= port_mem[in_entry.addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_b1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_b1 <= in_valid;
			end
			if (!out_valid_q || out_ready) begin
				out_valid_q <= adv_b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			op_b1        <= in_entry.op;
			echo_ip_b1   <= in_entry.echo_ip;
			echo_port_b1 <= in_entry.echo_port;
		end
		if (adv_b1) begin
			unique case (op_b1)
				vrbs_pkg::OP_READ: begin
					result_q <= '{verdict: 1'b1, rewritten: 1'b1,
						dest_ip: rd_ip_q, dest_port: rd_port_q};
				end
				vrbs_pkg::OP_DROP: begin
					result_q <= '{verdict: 1'b0, rewritten: 1'b0,
						dest_ip: echo_ip_b1, dest_port: echo_port_b1};
				end
				default: begin
					result_q <= '{verdict: 1'b1, rewritten: 1'b0,
						dest_ip: echo_ip_b1, dest_port: echo_port_b1};
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign out_result = result_q;

endmodule

// File: src/vip_random_backend_select.sv
// Throughput: one beat per cycle while m_tready stays high. Two front stages (slot match,
// backend index multiply) feed a two-entry queue, then the back end's read stage and
// output register; the back end does at most one backend memory access per beat.
// Reset: arst_n clears all slot valid flags, slot counts and pipeline control at once;
// the backend memory is not cleared, and no clearing pass is run.
module vip_random_backend_select (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [167:0] s_tdata,  // addr_family, virtual_ip, orig_port, random_word, slot_sel,
	                               // slot_enable, slot_count, backend_pos, backend_addr,
	                               // backend_port_in, zero fill
	input  logic [1:0]   s_tuser,  // cmd
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [47:0]  m_tdata,  // dest_ip, dest_port
	output logic [1:0]   m_tuser   // verdict, rewritten
);

	vrbs_pkg::item_t     item;
	vrbs_pkg::op_entry_t front_entry;
	vrbs_pkg::op_entry_t back_entry;
	vrbs_pkg::result_t   result;
	logic                front_valid;
	logic                front_ready;
	logic                back_valid;
	logic                back_ready;

	assign item.cmd             = s_tuser;
	assign item.addr_family     = s_tdata[15:0];
	assign item.virtual_ip      = s_tdata[47:16];
	assign item.orig_port       = s_tdata[63:48];
	assign item.random_word     = s_tdata[95:64];
	assign item.slot_sel        = s_tdata[99:96];
	assign item.slot_enable     = s_tdata[100];
	assign item.slot_count      = s_tdata[107:101];
	assign item.backend_pos     = s_tdata[113:108];
	assign item.backend_addr    = s_tdata[145:114];
	assign item.backend_port_in = s_tdata[161:146];

	vrbs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_item   (item),
		.out_valid (front_valid),
		.out_ready (front_ready),
		.out_entry (front_entry)
	);

	vrbs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_entry (front_entry),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready),
		.pop_entry  (back_entry)
	);

	vrbs_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (back_valid),
		.in_ready   (back_ready),
		.in_entry   (back_entry),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_result (result)
	);

	assign m_tdata = {result.dest_port, result.dest_ip};
	assign m_tuser = {result.rewritten, result.verdict};

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import vrbs_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int BK_DEPTH = VIP_SLOTS * MAX_BACKENDS;
	localparam int VIEW_PLAN = 0;
	localparam int VIEW_LIVE = 1;
	localparam int ITEM_TARGET = 1250;
	localparam int CYCLE_LIMIT = 800000;
	localparam int DRAIN_CYCLES = 8;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [167:0] s_tdata = '0;  // addr_family, virtual_ip, orig_port, random_word, slot_sel,
	                             // slot_enable, slot_count, backend_pos, backend_addr,
	                             // backend_port_in, zero fill
	logic [1:0]   s_tuser = '0;  // cmd
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [47:0]  m_tdata;       // dest_ip, dest_port
	logic [1:0]   m_tuser;       // verdict, rewritten

	vip_random_backend_select dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always #5 clk = ~clk;

	// Two copies of the balancer state: one tracks what has been queued so the
	// generator never steers a connect onto an unwritten backend entry, the other
	// advances only on accepted beats and produces the expected results.
	logic [31:0] lb_key     [2][VIP_SLOTS];
	bit          lb_valid   [2][VIP_SLOTS];
	logic [6:0]  lb_count   [2][VIP_SLOTS];
	logic [31:0] lb_bk_ip   [2][BK_DEPTH];
	logic [15:0] lb_bk_port [2][BK_DEPTH];
	bit          lb_written [2][BK_DEPTH];

	item_t   send_items[$];
	result_t want_results[$];
	item_t   cur_item;
	result_t got_res;
	result_t want_res;
	int      n_items = 0;
	int      err_count = 0;
	int      tx_gap = 0;
	int      tx_sent = 0;
	int      rx_hold = 0;
	int      beats_seen = 0;
	int      cycles = 0;
	logic [31:0] key_pool[8];

	function automatic int vip_match(int v, logic [31:0] vip);
		for (int s = 0; s < VIP_SLOTS; s++) begin
			if (lb_valid[v][s] && lb_key[v][s] == vip) return s;
		end
		return -1;
	endfunction

	function automatic int backend_span(int v, int s);
		return (lb_count[v][s] > MAX_BACKENDS) ? MAX_BACKENDS : int'(lb_count[v][s]);
	endfunction

	function automatic int pick_index(logic [31:0] rnd, int n);
		logic [63:0] prod;
		prod = 64'(rnd) * 64'(n);
		return (prod[63:32] >= n) ? 0 : int'(prod[63:32]);
	endfunction

	function automatic logic [31:0] word_for(int p, int n);
		return 32'(((64'(p) << 32) + 64'(n) - 64'd1) / 64'(n));
	endfunction

	function automatic result_t balance_step(int v, item_t it);
		result_t r;
		int s, n, a;
		r.verdict = 1'b1;
		r.rewritten = 1'b0;
		r.dest_ip = it.virtual_ip;
		r.dest_port = it.orig_port;
		case (it.cmd)
			CMD_SLOT: begin
				lb_key[v][it.slot_sel] = it.virtual_ip;
				lb_valid[v][it.slot_sel] = it.slot_enable;
				lb_count[v][it.slot_sel] = it.slot_count;
			end
			CMD_BACKEND: begin
				a = int'(it.slot_sel) * MAX_BACKENDS + int'(it.backend_pos);
				lb_bk_ip[v][a] = it.backend_addr;
				lb_bk_port[v][a] = it.backend_port_in;
				lb_written[v][a] = 1'b1;
			end
			CMD_CONNECT: begin
				s = (it.addr_family == FAMILY_IPV4) ? vip_match(v, it.virtual_ip) : -1;
				if (s >= 0) begin
					n = backend_span(v, s);
					if (n == 0) begin
						r.verdict = 1'b0;
					end else begin
						a = s * MAX_BACKENDS + pick_index(it.random_word, n);
						r.rewritten = 1'b1;
						r.dest_ip = lb_bk_ip[v][a];
						r.dest_port = lb_bk_port[v][a];
					end
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	function automatic item_t rand_item();
		item_t it;
		it.cmd = 2'($urandom);
		it.addr_family = 16'($urandom);
		it.virtual_ip = $urandom;
		it.orig_port = 16'($urandom);
		it.random_word = $urandom;
		it.slot_sel = 4'($urandom);
		it.slot_enable = 1'($urandom);
		it.slot_count = 7'($urandom);
		it.backend_pos = 6'($urandom);
		it.backend_addr = $urandom;
		it.backend_port_in = 16'($urandom);
		return it;
	endfunction

	function automatic item_t mk_slot(int sel, logic [31:0] key, bit en, int count);
		item_t it;
		it = rand_item();
		it.cmd = CMD_SLOT;
		it.slot_sel = 4'(sel);
		it.virtual_ip = key;
		it.slot_enable = en;
		it.slot_count = 7'(count);
		return it;
	endfunction

	function automatic item_t mk_backend(int sel, int pos, logic [31:0] ip, logic [15:0] port);
		item_t it;
		it = rand_item();
		it.cmd = CMD_BACKEND;
		it.slot_sel = 4'(sel);
		it.backend_pos = 6'(pos);
		it.backend_addr = ip;
		it.backend_port_in = port;
		return it;
	endfunction

	function automatic item_t mk_connect(logic [15:0] fam, logic [31:0] vip, logic [31:0] rnd);
		item_t it;
		it = rand_item();
		it.cmd = CMD_CONNECT;
		it.addr_family = fam;
		it.virtual_ip = vip;
		it.random_word = rnd;
		return it;
	endfunction

	task automatic push_item(item_t it);
		int s, n, idx, p;
		int spots[$];
		item_t fill;
		if (it.cmd == CMD_CONNECT && it.addr_family == FAMILY_IPV4) begin
			s = vip_match(VIEW_PLAN, it.virtual_ip);
			if (s >= 0 && backend_span(VIEW_PLAN, s) != 0) begin
				n = backend_span(VIEW_PLAN, s);
				idx = pick_index(it.random_word, n);
				if (!lb_written[VIEW_PLAN][s * MAX_BACKENDS + idx]) begin
					for (p = 0; p < n; p++) begin
						if (lb_written[VIEW_PLAN][s * MAX_BACKENDS + p]) spots.push_back(p);
					end
					if (spots.size() != 0) begin
						p = spots[$urandom_range(0, spots.size() - 1)];
						it.random_word = word_for(p, n);
					end else begin
						fill = mk_backend(s, idx, $urandom, 16'($urandom));
						void'(balance_step(VIEW_PLAN, fill));
						send_items.push_back(fill);
						n_items++;
					end
				end
			end
		end
		void'(balance_step(VIEW_PLAN, it));
		send_items.push_back(it);
		n_items++;
	endtask

	function automatic int pick_gap(int phase);
		int r;
		r = $urandom_range(0, 99);
		if ((phase % 256) < 48) return 0;
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic int pick_count();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return $urandom_range(1, 8);
		if (r < 70) return $urandom_range(9, 63);
		if (r < 80) return MAX_BACKENDS;
		if (r < 90) return $urandom_range(MAX_BACKENDS + 1, 127);
		return 0;
	endfunction

	function automatic logic [31:0] pool_key();
		return ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, 7)] : $urandom;
	endfunction

	task automatic random_sequence();
		int sel, count, span, nb, r;
		logic [31:0] key;
		sel = $urandom_range(0, VIP_SLOTS - 1);
		key = pool_key();
		count = pick_count();
		push_item(mk_slot(sel, key, $urandom_range(0, 99) < 90, count));
		span = (count > MAX_BACKENDS) ? MAX_BACKENDS : count;
		if (span <= 8) begin
			for (int p = 0; p < span; p++) push_item(mk_backend(sel, p, $urandom, 16'($urandom)));
		end else begin
			nb = $urandom_range(4, 10);
			for (int i = 0; i < nb; i++) begin
				push_item(mk_backend(sel, $urandom_range(0, span - 1), $urandom, 16'($urandom)));
			end
			if ($urandom_range(0, 1)) push_item(mk_backend(sel, span - 1, $urandom, 16'($urandom)));
		end
		r = $urandom_range(2, 6);
		for (int i = 0; i < r; i++) push_item(mk_connect(FAMILY_IPV4, key, $urandom));
	endtask

	task automatic build_stimulus();
		item_t it;
		int r;
		push_item(mk_connect(FAMILY_IPV4, 32'h0, $urandom));
		it = '1;
		it.cmd = CMD_UNUSED;
		push_item(it);
		push_item(mk_slot(0, 32'hFFFF_FFFF, 1'b1, 0));
		push_item(mk_connect(FAMILY_IPV4, 32'hFFFF_FFFF, $urandom));
		push_item(mk_slot(15, 32'h0, 1'b1, 127));
		push_item(mk_backend(15, MAX_BACKENDS - 1, 32'hFFFF_FFFF, 16'hFFFF));
		push_item(mk_backend(15, 0, 32'h0, 16'h0));
		push_item(mk_connect(FAMILY_IPV4, 32'h0, 32'hFFFF_FFFF));
		push_item(mk_connect(FAMILY_IPV4, 32'h0, 32'h0));
		push_item(mk_connect(16'hFFFF, 32'h0, $urandom));
		push_item(mk_connect(16'h0, 32'h0, $urandom));
		push_item(mk_slot(3, 32'h0, 1'b1, 1));
		push_item(mk_backend(3, 0, $urandom, 16'($urandom)));
		push_item(mk_connect(FAMILY_IPV4, 32'h0, $urandom));
		push_item(mk_slot(3, 32'h0, 1'b0, 1));
		push_item(mk_connect(FAMILY_IPV4, 32'h0, 32'h0));
		push_item(mk_slot(5, 32'h0A00_0001, 1'b1, MAX_BACKENDS));
		push_item(mk_backend(5, MAX_BACKENDS - 1, $urandom, 16'($urandom)));
		push_item(mk_connect(FAMILY_IPV4, 32'h0A00_0001, 32'hFFFF_FFFF));
		push_item(mk_slot(0, 32'hFFFF_FFFF, 1'b0, 0));
		push_item(mk_connect(FAMILY_IPV4, 32'hFFFF_FFFF, $urandom));

		while (n_items < ITEM_TARGET) begin
			r = $urandom_range(0, 99);
			if (r < 50) begin
				random_sequence();
			end else if (r < 70) begin
				push_item(mk_connect(FAMILY_IPV4, pool_key(), $urandom));
			end else if (r < 80) begin
				push_item(mk_connect(($urandom_range(0, 1) ? FAMILY_IPV4 : 16'($urandom)),
					$urandom, $urandom));
			end else if (r < 90) begin
				push_item(mk_backend($urandom_range(0, VIP_SLOTS - 1),
					$urandom_range(0, MAX_BACKENDS - 1), $urandom, 16'($urandom)));
			end else if (r < 95) begin
				it = rand_item();
				it.cmd = CMD_UNUSED;
				push_item(it);
			end else begin
				push_item(mk_slot($urandom_range(0, VIP_SLOTS - 1), pool_key(),
					$urandom_range(0, 1), 7'($urandom)));
			end
		end
	endtask

	task automatic report(string fld, logic [31:0] want, logic [31:0] got);
		if (err_count < 40) $display("%0t: %s expected %0h got %0h", $time, fld, want, got);
		err_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			if (s_tvalid) begin
				want_results.push_back(balance_step(VIEW_LIVE, cur_item));
				tx_sent++;
			end
			if (tx_gap != 0) begin
				tx_gap <= tx_gap - 1;
				s_tvalid <= 1'b0;
			end else if (send_items.size() != 0) begin
				cur_item = send_items.pop_front();
				s_tdata <= {6'b0, cur_item.backend_port_in, cur_item.backend_addr,
					cur_item.backend_pos, cur_item.slot_count, cur_item.slot_enable,
					cur_item.slot_sel, cur_item.random_word, cur_item.orig_port,
					cur_item.virtual_ip, cur_item.addr_family};
				s_tuser <= cur_item.cmd;
				s_tvalid <= 1'b1;
				tx_gap <= pick_gap(tx_sent);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got_res.verdict = m_tuser[0];
				got_res.rewritten = m_tuser[1];
				got_res.dest_ip = m_tdata[31:0];
				got_res.dest_port = m_tdata[47:32];
				if (want_results.size() == 0) begin
					report("unexpected beat, dest_ip", 32'hx, got_res.dest_ip);
				end else begin
					want_res = want_results.pop_front();
					if (got_res.verdict !== want_res.verdict)
						report("verdict", want_res.verdict, got_res.verdict);
					if (got_res.rewritten !== want_res.rewritten)
						report("rewritten", want_res.rewritten, got_res.rewritten);
					if (got_res.dest_ip !== want_res.dest_ip)
						report("dest_ip", want_res.dest_ip, got_res.dest_ip);
					if (got_res.dest_port !== want_res.dest_port)
						report("dest_port", want_res.dest_port, got_res.dest_port);
				end
				beats_seen++;
			end
			// A long hold-off twice in the run lets the block fill up and stall its input.
			if (m_tvalid && m_tready && (beats_seen == 201 || beats_seen == 801)) begin
				rx_hold <= 400;
				m_tready <= 1'b0;
			end else if (rx_hold != 0) begin
				rx_hold <= rx_hold - 1;
				m_tready <= 1'b0;
			end else if ((beats_seen % 256) >= 96 && $urandom_range(0, 99) < 20) begin
				rx_hold <= pick_gap(beats_seen);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		for (int v = 0; v < 2; v++) begin
			for (int s = 0; s < VIP_SLOTS; s++) begin
				lb_key[v][s] = '0;
				lb_valid[v][s] = 1'b0;
				lb_count[v][s] = '0;
			end
			for (int a = 0; a < BK_DEPTH; a++) begin
				lb_bk_ip[v][a] = '0;
				lb_bk_port[v][a] = '0;
				lb_written[v][a] = 1'b0;
			end
		end
		key_pool[0] = 32'h0;
		key_pool[1] = 32'hFFFF_FFFF;
		for (int i = 2; i < 8; i++) key_pool[i] = $urandom;
		build_stimulus();

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (send_items.size() != 0 || s_tvalid || want_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// File: sim.f
src/vrbs_pkg.sv
src/vrbs_front.sv
src/vrbs_queue.sv
src/vrbs_back.sv
src/vip_random_backend_select.sv
tb/tb_top.sv
